// ----- hw/rtl/olt_pkg.sv -----
// ----------------------------------------------------------------------------
// olt_pkg: shared definitions for the ordered list table
// Command codes, field widths, default sizes and the cell control bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package olt_pkg;

    // Widths of the request and response fields.
    localparam int COMMAND_W = 3;
    localparam int SLOT_W    = 5;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 4;
    localparam int COUNT_W   = 5;

    // Default geometry of the list.
    localparam int DEPTH_DEFAULT      = 16;
    localparam int ITEM_WIDTH_DEFAULT = 32;

    // Command codes.
    localparam logic [COMMAND_W-1:0] CMD_APPEND   = 3'd0;
    localparam logic [COMMAND_W-1:0] CMD_INSERT   = 3'd1;
    localparam logic [COMMAND_W-1:0] CMD_DELETE   = 3'd2;
    localparam logic [COMMAND_W-1:0] CMD_FIND     = 3'd3;
    localparam logic [COMMAND_W-1:0] CMD_FIND_DEL = 3'd4;
    localparam logic [COMMAND_W-1:0] CMD_READ     = 3'd5;

    // What every cell does with its entry at the next edge.
    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_INSERT,
        ACT_REMOVE_IDX,
        ACT_REMOVE_HIT
    } cell_act_t;

    typedef struct packed {
        logic      compare;   // capture the match flag this cycle
        logic      by_index;  // match on the slot number instead of the key
        cell_act_t act;
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/olt_cmd_if.sv -----
// ----------------------------------------------------------------------------
// olt_cmd_if: request channel of the ordered list table
// Valid/ready handshake carrying command, slot index and item value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface olt_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [olt_pkg::COMMAND_W-1:0] command;
    logic [olt_pkg::SLOT_W-1:0]    slot_index;
    logic [olt_pkg::VALUE_W-1:0]   item_value;

    modport source (
        output valid,
        output command,
        output slot_index,
        output item_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  command,
        input  slot_index,
        input  item_value,
        output ready
    );
endinterface

// ----- hw/rtl/olt_rsp_if.sv -----
// ----------------------------------------------------------------------------
// olt_rsp_if: response channel of the ordered list table
// Valid/ready handshake carrying status, position, read data and count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface olt_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        ok;
    logic                        found;
    logic [olt_pkg::POS_W-1:0]   position;
    logic [olt_pkg::VALUE_W-1:0] read_data;
    logic [olt_pkg::COUNT_W-1:0] entry_count;

    modport source (
        output valid,
        output ok,
        output found,
        output position,
        output read_data,
        output entry_count,
        input  ready
    );

    modport sink (
        input  valid,
        input  ok,
        input  found,
        input  position,
        input  read_data,
        input  entry_count,
        output ready
    );
endinterface

// ----- hw/rtl/olt_cell.sv -----
// ----------------------------------------------------------------------------
// olt_cell: one slot of the ordered list
// Holds one entry and its match flag, compares against the key (or its slot
// number against the selected position) and shifts to or from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olt_cell #(
    parameter int DEPTH      = olt_pkg::DEPTH_DEFAULT,
    parameter int ITEM_WIDTH = olt_pkg::ITEM_WIDTH_DEFAULT,
    parameter int CELL_INDEX = 0
) (
    input  logic                                  clk,
    input  olt_pkg::cell_ctrl_t                   ctrl,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] sel_pos,
    input  logic [$clog2(DEPTH + 1)-1:0]          count,
    input  logic [ITEM_WIDTH-1:0]                 key,
    input  logic [ITEM_WIDTH-1:0]                 lower_entry,
    input  logic [ITEM_WIDTH-1:0]                 upper_entry,
    input  logic                                  seen_in,
    output logic [ITEM_WIDTH-1:0]                 entry,
    output logic                                  seen_out,
    output logic                                  first_hit,
    output logic [ITEM_WIDTH-1:0]                 picked_word
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [IW-1:0] MY_INDEX = IW'(CELL_INDEX);

    logic [ITEM_WIDTH-1:0] entry_reg;
    logic [ITEM_WIDTH-1:0] entry_next;
    logic                  match_reg;
    logic                  match_next;
    logic                  below_count;
    logic                  next_held;
    logic                  last_held;
    logic                  shift_here;

    assign below_count = CW'(CELL_INDEX) < count;
    assign next_held   = CW'(CELL_INDEX + 1) < count;
    assign last_held   = CW'(CELL_INDEX + 1) == count;

    always_comb
    begin
        entry_next = entry_reg;
        match_next = match_reg;
        shift_here = 1'b0;

        if (ctrl.compare)
        begin
            if (ctrl.by_index)
            begin
                match_next = (MY_INDEX == sel_pos);
            end
            else
            begin
                match_next = (entry_reg == key) && below_count;
            end
        end

        case (ctrl.act)
            olt_pkg::ACT_INSERT:
            begin
                if (MY_INDEX == sel_pos)
                begin
                    entry_next = key;
                end
                else if ((MY_INDEX > sel_pos) && (CW'(CELL_INDEX) <= count))
                begin
                    entry_next = lower_entry;
                end
            end
            olt_pkg::ACT_REMOVE_IDX,
            olt_pkg::ACT_REMOVE_HIT:
            begin
                // Every occupied cell at or above the removed slot, below the top,
                // takes its upper neighbor; the old top entry is cleared.
                if (ctrl.act == olt_pkg::ACT_REMOVE_IDX)
                begin
                    shift_here = MY_INDEX >= sel_pos;
                end
                else
                begin
                    shift_here = seen_in || match_reg;
                end
                if (shift_here)
                begin
                    if (next_held)
                    begin
                        entry_next = upper_entry;
                    end
                    else if (last_held)
                    begin
                        entry_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

    assign entry       = entry_reg;
    assign seen_out    = seen_in || match_reg;
    assign first_hit   = match_reg && !seen_in;
    assign picked_word = match_reg ? entry_reg : '0;

endmodule

// ----- hw/rtl/ordered_list_table.sv -----
// ----------------------------------------------------------------------------
// ordered_list_table: fixed-capacity ordered list in a chain of shift cells
// A new request is taken only once the previous one has finished its steps:
// accept, compare in all cells, then shift the chain and register the
// response; a held response stalls only the final step. Reset clears the
// entry count and the handshake state; entry storage is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_list_table #(
    parameter int DEPTH      = olt_pkg::DEPTH_DEFAULT,
    parameter int ITEM_WIDTH = olt_pkg::ITEM_WIDTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    olt_cmd_if.sink    request,
    olt_rsp_if.source  response
);

    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > olt_pkg::SLOT_W) ? CW : olt_pkg::SLOT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } state_t;

    state_t                          state_reg,       state_next;
    logic [olt_pkg::COMMAND_W-1:0]   cmd_reg,         cmd_next;
    logic [olt_pkg::SLOT_W-1:0]      idx_reg,         idx_next;
    logic [ITEM_WIDTH-1:0]           value_reg,       value_next;
    logic [CW-1:0]                   count_reg,       count_next;
    logic                            rsp_valid_reg,   rsp_valid_next;
    logic                            ok_reg,          ok_next;
    logic                            found_reg,       found_next;
    logic [olt_pkg::POS_W-1:0]       position_reg,    position_next;
    logic [olt_pkg::VALUE_W-1:0]     read_data_reg,   read_data_next;

    olt_pkg::cell_ctrl_t             ctrl;
    logic [IW-1:0]                   sel_pos;

    logic [ITEM_WIDTH-1:0]           entry_w  [DEPTH];
    logic [ITEM_WIDTH-1:0]           picked_w [DEPTH];
    logic                            first_w  [DEPTH];
    logic                            seen_w   [DEPTH+1];

    logic [IW-1:0]                   hit_pos;
    logic [ITEM_WIDTH-1:0]           read_word;
    logic                            any_hit;
    logic                            full;
    logic                            idx_below;
    logic                            idx_at_most;
    logic                            go;

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    assign seen_w[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [ITEM_WIDTH-1:0] lower;
        logic [ITEM_WIDTH-1:0] upper;

        if (g == 0)
        begin : g_bottom
            assign lower = '0;
        end
        else
        begin : g_lower
            assign lower = entry_w[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_top
            assign upper = '0;
        end
        else
        begin : g_upper
            assign upper = entry_w[g+1];
        end

        olt_cell #(
            .DEPTH      (DEPTH),
            .ITEM_WIDTH (ITEM_WIDTH),
            .CELL_INDEX (g)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .sel_pos     (sel_pos),
            .count       (count_reg),
            .key         (value_reg),
            .lower_entry (lower),
            .upper_entry (upper),
            .seen_in     (seen_w[g]),
            .entry       (entry_w[g]),
            .seen_out    (seen_w[g+1]),
            .first_hit   (first_w[g]),
            .picked_word (picked_w[g])
        );
    end

    assign any_hit = seen_w[DEPTH];

    // At most one cell flags the first hit, and only the addressed cell
    // offers its word on a read, so plain OR trees collect both.
    always_comb
    begin
        hit_pos   = '0;
        read_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first_w[i])
            begin
                hit_pos = hit_pos | IW'(i);
            end
            read_word = read_word | picked_w[i];
        end
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    assign full        = (count_reg == CW'(DEPTH));
    assign idx_below   = CMPW'(idx_reg) < CMPW'(count_reg);
    assign idx_at_most = CMPW'(idx_reg) <= CMPW'(count_reg);
    assign go          = !rsp_valid_reg || response.ready;

    assign request.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        value_next     = value_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        ok_next        = ok_reg;
        found_next     = found_reg;
        position_next  = position_reg;
        read_data_next = read_data_reg;
        ctrl.compare   = 1'b0;
        ctrl.by_index  = 1'b0;
        ctrl.act       = olt_pkg::ACT_HOLD;
        sel_pos        = IW'(idx_reg);

        if (rsp_valid_reg && response.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    cmd_next   = request.command;
                    idx_next   = request.slot_index;
                    value_next = ITEM_WIDTH'(request.item_value);
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                ctrl.compare  = 1'b1;
                ctrl.by_index = (cmd_reg == olt_pkg::CMD_READ);
                state_next    = S_EXEC;
            end
            S_EXEC:
            begin
                if (go)
                begin
                    rsp_valid_next = 1'b1;
                    ok_next        = 1'b0;
                    found_next     = 1'b0;
                    position_next  = '0;
                    read_data_next = '0;
                    state_next     = S_IDLE;

                    case (cmd_reg)
                        olt_pkg::CMD_APPEND:
                        begin
                            if (!full)
                            begin
                                ok_next       = 1'b1;
                                position_next = olt_pkg::POS_W'(count_reg);
                                sel_pos       = IW'(count_reg);
                                ctrl.act      = olt_pkg::ACT_INSERT;
                                count_next    = CW'(count_reg + CW'(1));
                            end
                        end
                        olt_pkg::CMD_INSERT:
                        begin
                            if (!full && idx_at_most)
                            begin
                                ok_next       = 1'b1;
                                position_next = olt_pkg::POS_W'(idx_reg);
                                ctrl.act      = olt_pkg::ACT_INSERT;
                                count_next    = CW'(count_reg + CW'(1));
                            end
                        end
                        olt_pkg::CMD_DELETE:
                        begin
                            if (idx_below)
                            begin
                                ok_next    = 1'b1;
                                ctrl.act   = olt_pkg::ACT_REMOVE_IDX;
                                count_next = CW'(count_reg - CW'(1));
                            end
                        end
                        olt_pkg::CMD_FIND,
                        olt_pkg::CMD_FIND_DEL:
                        begin
                            ok_next = 1'b1;
                            if (any_hit)
                            begin
                                found_next    = 1'b1;
                                position_next = olt_pkg::POS_W'(hit_pos);
                                if (cmd_reg == olt_pkg::CMD_FIND_DEL)
                                begin
                                    ctrl.act   = olt_pkg::ACT_REMOVE_HIT;
                                    count_next = CW'(count_reg - CW'(1));
                                end
                            end
                        end
                        olt_pkg::CMD_READ:
                        begin
                            if (idx_below)
                            begin
                                ok_next        = 1'b1;
                                read_data_next = olt_pkg::VALUE_W'(read_word);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            idx_reg       <= '0;
            value_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            found_reg     <= 1'b0;
            position_reg  <= '0;
            read_data_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            idx_reg       <= idx_next;
            value_reg     <= value_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            ok_reg        <= ok_next;
            found_reg     <= found_next;
            position_reg  <= position_next;
            read_data_reg <= read_data_next;
        end
    end

    assign response.valid       = rsp_valid_reg;
    assign response.ok          = ok_reg;
    assign response.found       = found_reg;
    assign response.position    = position_reg;
    assign response.read_data   = read_data_reg;
    assign response.entry_count = olt_pkg::COUNT_W'(count_reg);

endmodule
